// ----- rtl/core/ssfh_pkg.sv -----
// ssfh_pkg: widths, lane codes and payload types of the segment/square hit block.
// No dependencies; every other file of the block imports it.
`timescale 1ns / 1ps

package ssfh_pkg;

   // fixed point default
   localparam int FRAC_BITS_DEF = 16;

   // field and internal widths
   localparam int COORD_W = 32;               // input coordinates
   localparam int HALF_W  = 31;               // half size
   localparam int SIDE_W  = HALF_W + 1;       // full side length
   localparam int DELTA_W = COORD_W + 1;      // segment delta
   localparam int REL_W   = COORD_W + 2;      // edge corner minus segment start
   localparam int PARAM_W = 32;               // line parameter t
   localparam int LO_W    = 17;               // low split of a multiplier operand
   localparam int PW_LO   = REL_W + LO_W + 1; // low partial product
   localparam int PW_HI   = REL_W + DELTA_W - LO_W; // high partial product
   localparam int PROD_W  = REL_W + DELTA_W + 1;    // full products and sums

   // edge lanes, in test order
   localparam int NUM_EDGES   = 4;
   localparam int EDGE_LEFT   = 0;
   localparam int EDGE_RIGHT  = 1;
   localparam int EDGE_BOTTOM = 2;
   localparam int EDGE_TOP    = 3;

   typedef struct packed {
      logic signed [COORD_W-1:0] start_x;
      logic signed [COORD_W-1:0] start_y;
      logic signed [COORD_W-1:0] end_x;
      logic signed [COORD_W-1:0] end_y;
      logic signed [COORD_W-1:0] centre_x;
      logic signed [COORD_W-1:0] centre_y;
      logic [HALF_W-1:0]         half_size;
   } ssfh_req_type;

   // one edge: t = tn * 2^F / td, qual marks a crossing on the edge
   typedef struct packed {
      logic signed [REL_W-1:0]   tn;
      logic signed [DELTA_W-1:0] td;
      logic                      qual;
   } ssfh_lane_type;

   typedef struct packed {
      logic signed [PARAM_W-1:0] t;
      logic                      qual;
   } ssfh_cand_type;

   typedef struct packed {
      logic                      hit;
      logic signed [PARAM_W-1:0] hit_param;
   } ssfh_rsp_type;

endpackage

// ----- rtl/core/ssfh_req_if.sv -----
// ssfh_req_if: request channel, valid/ready plus segment and square fields.
// Depends on ssfh_pkg.
`timescale 1ns / 1ps

interface ssfh_req_if import ssfh_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic signed [COORD_W-1:0] start_x;
   logic signed [COORD_W-1:0] start_y;
   logic signed [COORD_W-1:0] end_x;
   logic signed [COORD_W-1:0] end_y;
   logic signed [COORD_W-1:0] centre_x;
   logic signed [COORD_W-1:0] centre_y;
   logic [HALF_W-1:0]         half_size;

   modport source (output valid, start_x, start_y, end_x, end_y, centre_x, centre_y,
                   half_size, input ready);
   modport sink (input valid, start_x, start_y, end_x, end_y, centre_x, centre_y,
                 half_size, output ready);
endinterface

// ----- rtl/core/ssfh_rsp_if.sv -----
// ssfh_rsp_if: result channel, valid/ready plus hit flag and parameter.
// Depends on ssfh_pkg.
`timescale 1ns / 1ps

interface ssfh_rsp_if import ssfh_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic                      hit;
   logic signed [PARAM_W-1:0] hit_param;

   modport source (output valid, hit, hit_param, input ready);
   modport sink (input valid, hit, hit_param, output ready);
endinterface

// ----- rtl/core/segment_square_first_hit.sv -----
// segment_square_first_hit: top level, smallest line parameter at which the
// segment's line crosses a square edge. Depends on ssfh_pkg, the channel
// interfaces, ssfh_geom, ssfh_div, ssfh_pick and ssfh_skid.
//
//   channel   direction  contents
//   req_chan  in         start_x/y, end_x/y, centre_x/y, half_size
//   rsp_chan  out        hit, hit_param
//
// One request enters per cycle while the output queue has room; a result passes
// through 5 geometry stages, 35 divider stages and 2 minimum stages, then the queue.
// Most of the depth is in the divider, whose step stages retire one quotient bit each.
// Reset clears all valid bits and the output queue; no clearing pass.
// All stages advance together while the two-entry output queue has room, so
// a request is still taken while one finished result waits.
`timescale 1ns / 1ps

module segment_square_first_hit import ssfh_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic     clock,
   input  logic     reset,
   ssfh_req_if.sink   req_chan,
   ssfh_rsp_if.source rsp_chan
);

   logic                          en;
   ssfh_req_type                  req;
   logic                          geom_valid;
   ssfh_lane_type [NUM_EDGES-1:0] lanes;
   logic [NUM_EDGES-1:0]          div_valid;
   ssfh_cand_type [NUM_EDGES-1:0] cands;
   logic                          pick_valid;
   ssfh_rsp_type                  pick_rsp;
   ssfh_rsp_type                  out_rsp;

   assign req_chan.ready = en;

   always_comb begin
      req.start_x   = req_chan.start_x;
      req.start_y   = req_chan.start_y;
      req.end_x     = req_chan.end_x;
      req.end_y     = req_chan.end_y;
      req.centre_x  = req_chan.centre_x;
      req.centre_y  = req_chan.centre_y;
      req.half_size = req_chan.half_size;
   end

   ssfh_geom u_geom (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_chan.valid),
      .in_req    (req),
      .out_valid (geom_valid),
      .out_lane  (lanes)
   );

   // one divider per edge
   for (genvar e = 0; e < NUM_EDGES; e++) begin : g_div
      ssfh_div #(.FRAC_BITS(FRAC_BITS)) u_div (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (geom_valid),
         .in_lane   (lanes[e]),
         .out_valid (div_valid[e]),
         .out_cand  (cands[e])
      );
   end

   ssfh_pick u_pick (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (&div_valid),
      .in_cand   (cands),
      .out_valid (pick_valid),
      .out_rsp   (pick_rsp)
   );

   ssfh_skid u_skid (
      .clock     (clock),
      .reset     (reset),
      .push      (pick_valid && en),
      .push_rsp  (pick_rsp),
      .room      (en),
      .out_valid (rsp_chan.valid),
      .out_ready (rsp_chan.ready),
      .out_rsp   (out_rsp)
   );

   assign rsp_chan.hit       = out_rsp.hit;
   assign rsp_chan.hit_param = out_rsp.hit_param;

endmodule

// ----- rtl/core/ssfh_geom.sv -----
// ssfh_geom: five-stage front end, edge offsets, cross products, on-edge tests.
// Depends on ssfh_pkg.
`timescale 1ns / 1ps

module ssfh_geom import ssfh_pkg::*; (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           en,
   input  logic                           in_valid,
   input  ssfh_req_type                   in_req,
   output logic                           out_valid,
   output ssfh_lane_type [NUM_EDGES-1:0]  out_lane
);

   // stage 1: deltas and edge corner offsets
   logic signed [REL_W-1:0]   sx, sy, ex, ey, cx, cy, rr;
   logic signed [DELTA_W-1:0] dx_in, dy_in;
   logic signed [REL_W-1:0]   rxl_in, rxr_in, ryb_in, ryt_in;
   logic signed [DELTA_W-1:0] dx1_ff, dy1_ff;
   logic signed [REL_W-1:0]   rxl1_ff, rxr1_ff, ryb1_ff, ryt1_ff;
   logic [SIDE_W-1:0]         side1_ff;
   logic                      v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;

   always_comb begin
      sx = REL_W'(in_req.start_x);
      sy = REL_W'(in_req.start_y);
      ex = REL_W'(in_req.end_x);
      ey = REL_W'(in_req.end_y);
      cx = REL_W'(in_req.centre_x);
      cy = REL_W'(in_req.centre_y);
      rr = signed'(REL_W'(in_req.half_size));
      dx_in  = DELTA_W'(ex - sx);
      dy_in  = DELTA_W'(ey - sy);
      rxl_in = cx - rr - sx;
      rxr_in = cx + rr - sx;
      ryb_in = cy - rr - sy;
      ryt_in = cy + rr - sy;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dx1_ff   <= dx_in;
         dy1_ff   <= dy_in;
         rxl1_ff  <= rxl_in;
         rxr1_ff  <= rxr_in;
         ryb1_ff  <= ryb_in;
         ryt1_ff  <= ryt_in;
         side1_ff <= {in_req.half_size, 1'b0};
      end
   end

   // edge lanes: vertical edges divide by dx, horizontal by dy
   ssfh_lane_type [NUM_EDGES-1:0] lane1;
   ssfh_lane_type [NUM_EDGES-1:0] lane2_ff, lane3_ff, lane4_ff, lane5_ff;

   always_comb begin
      lane1[EDGE_LEFT]   = '{tn: rxl1_ff, td: dx1_ff, qual: 1'b0};
      lane1[EDGE_RIGHT]  = '{tn: rxr1_ff, td: dx1_ff, qual: 1'b0};
      lane1[EDGE_BOTTOM] = '{tn: ryb1_ff, td: dy1_ff, qual: 1'b0};
      lane1[EDGE_TOP]    = '{tn: ryt1_ff, td: dy1_ff, qual: 1'b0};
   end

   // stage 2: partial products, operands split into high and low halves
   logic signed [LO_W:0]          dx_lo, dy_lo;
   logic signed [DELTA_W-LO_W-1:0] dx_hi, dy_hi;
   logic signed [SIDE_W:0]        side_s;
   logic signed [PW_LO-1:0]       alo_ff, blo_ff, clo_ff, dlo_ff;
   logic signed [PW_HI-1:0]       ahi_ff, bhi_ff, chi_ff, dhi_ff;

   always_comb begin
      dx_lo  = signed'({1'b0, dx1_ff[LO_W-1:0]});
      dy_lo  = signed'({1'b0, dy1_ff[LO_W-1:0]});
      dx_hi  = signed'(dx1_ff[DELTA_W-1:LO_W]);
      dy_hi  = signed'(dy1_ff[DELTA_W-1:LO_W]);
      side_s = signed'({1'b0, side1_ff});
   end

   always_ff @(posedge clock) begin
      if (en) begin
         alo_ff   <= rxl1_ff * dy_lo;
         ahi_ff   <= rxl1_ff * dy_hi;
         blo_ff   <= ryb1_ff * dx_lo;
         bhi_ff   <= ryb1_ff * dx_hi;
         clo_ff   <= side_s * dx_lo;
         chi_ff   <= side_s * dx_hi;
         dlo_ff   <= side_s * dy_lo;
         dhi_ff   <= side_s * dy_hi;
         lane2_ff <= lane1;
      end
   end

   // stage 3: full products A = rxl*dy, B = ryb*dx, C = side*dx, D = side*dy
   logic signed [PROD_W-1:0] a3_ff, b3_ff, c3_ff, d3_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         a3_ff    <= (PROD_W'(ahi_ff) <<< LO_W) + PROD_W'(alo_ff);
         b3_ff    <= (PROD_W'(bhi_ff) <<< LO_W) + PROD_W'(blo_ff);
         c3_ff    <= (PROD_W'(chi_ff) <<< LO_W) + PROD_W'(clo_ff);
         d3_ff    <= (PROD_W'(dhi_ff) <<< LO_W) + PROD_W'(dlo_ff);
         lane3_ff <= lane2_ff;
      end
   end

   // stage 4: numerators; right adds D, top subtracts C, bottom shares left
   logic signed [PROD_W-1:0] n0_ff, n1_ff, n3_ff, c4_ff, dn4_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         n0_ff    <= a3_ff - b3_ff;
         n1_ff    <= a3_ff - b3_ff + d3_ff;
         n3_ff    <= a3_ff - b3_ff - c3_ff;
         c4_ff    <= c3_ff;
         dn4_ff   <= -d3_ff;
         lane4_ff <= lane3_ff;
      end
   end

   // stage 5: crossing lies on the edge when num/den is within [0,1]
   function automatic logic on_edge(input logic signed [PROD_W-1:0] num,
                                    input logic signed [PROD_W-1:0] den);
      logic ok;
      if (den == '0) begin
         ok = 1'b0;
      end else if (!den[PROD_W-1]) begin
         ok = !num[PROD_W-1] && (num <= den);
      end else begin
         ok = (num[PROD_W-1] || (num == '0)) && (num >= den);
      end
      return ok;
   endfunction

   ssfh_lane_type [NUM_EDGES-1:0] lane5_in;

   always_comb begin
      lane5_in                   = lane4_ff;
      lane5_in[EDGE_LEFT].qual   = on_edge(n0_ff, c4_ff);
      lane5_in[EDGE_RIGHT].qual  = on_edge(n1_ff, c4_ff);
      lane5_in[EDGE_BOTTOM].qual = on_edge(n0_ff, dn4_ff);
      lane5_in[EDGE_TOP].qual    = on_edge(n3_ff, dn4_ff);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         lane5_ff <= lane5_in;
      end
   end

   // valid chain
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
      end
   end

   assign out_valid = v5_ff;
   assign out_lane  = lane5_ff;

endmodule

// ----- rtl/core/ssfh_div.sv -----
// ssfh_div: pipelined restoring divider, t = tn * 2^F / td, toward zero, saturated.
// Depends on ssfh_pkg.
`timescale 1ns / 1ps

module ssfh_div import ssfh_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          en,
   input  logic          in_valid,
   input  ssfh_lane_type in_lane,
   output logic          out_valid,
   output ssfh_cand_type out_cand
);

   localparam int MW    = REL_W + FRAC_BITS;            // scaled dividend
   localparam int RW    = (MW > DELTA_W + PARAM_W) ? MW : DELTA_W + PARAM_W;
   localparam int STEPS = PARAM_W;

   // prep: magnitudes and result sign
   logic [REL_W-1:0]   tn_mag;
   logic [DELTA_W-1:0] td_mag;
   logic [RW-1:0]      m_ff;
   logic [DELTA_W-1:0] vp_ff;
   logic               sp_ff, qp_ff, validp_ff;

   always_comb begin
      tn_mag = in_lane.tn[REL_W-1] ? unsigned'(-in_lane.tn) : unsigned'(in_lane.tn);
      td_mag = in_lane.td[DELTA_W-1] ? unsigned'(-in_lane.td) : unsigned'(in_lane.td);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         m_ff  <= RW'(tn_mag) << FRAC_BITS;
         vp_ff <= td_mag;
         sp_ff <= in_lane.tn[REL_W-1] ^ in_lane.td[DELTA_W-1];
         qp_ff <= in_lane.qual;
      end
   end

   // step chain; index 0 holds the overflow check result
   logic [RW-1:0]      rem_ff  [0:STEPS];
   logic [PARAM_W-1:0] quo_ff  [0:STEPS];
   logic [DELTA_W-1:0] v_ff    [0:STEPS];
   logic               sign_ff [0:STEPS];
   logic               ovf_ff  [0:STEPS];
   logic               qual_ff [0:STEPS];
   logic               vld_ff  [0:STEPS];

   // quotient of 2^32 or more saturates in either sign
   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0]  <= m_ff;
         quo_ff[0]  <= '0;
         v_ff[0]    <= vp_ff;
         sign_ff[0] <= sp_ff;
         ovf_ff[0]  <= (m_ff >= (RW'(vp_ff) << PARAM_W));
         qual_ff[0] <= qp_ff;
      end
   end

   // one quotient bit per stage, most significant first
   for (genvar k = 0; k < STEPS; k++) begin : g_step
      localparam int J = STEPS - 1 - k;
      logic [RW:0]        trial;
      logic               ge;
      logic [PARAM_W-1:0] quo_in;

      always_comb begin
         trial     = {1'b0, rem_ff[k]} - {1'b0, RW'(v_ff[k]) << J};
         ge        = !trial[RW];
         quo_in    = quo_ff[k];
         quo_in[J] = ge;
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k+1]  <= ge ? trial[RW-1:0] : rem_ff[k];
            quo_ff[k+1]  <= quo_in;
            v_ff[k+1]    <= v_ff[k];
            sign_ff[k+1] <= sign_ff[k];
            ovf_ff[k+1]  <= ovf_ff[k];
            qual_ff[k+1] <= qual_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k+1] <= 1'b0;
         end else if (en) begin
            vld_ff[k+1] <= vld_ff[k];
         end
      end
   end

   // sign and saturation
   localparam logic [PARAM_W-1:0] MAG_NEG = {1'b1, {(PARAM_W-1){1'b0}}};
   logic [PARAM_W-1:0]        q;
   logic signed [PARAM_W-1:0] t_in;
   ssfh_cand_type             cand_ff;
   logic                      validf_ff;

   always_comb begin
      q = quo_ff[STEPS];
      if (sign_ff[STEPS]) begin
         if (ovf_ff[STEPS] || (q > MAG_NEG)) begin
            t_in = signed'(MAG_NEG);
         end else begin
            t_in = -signed'(q);
         end
      end else begin
         if (ovf_ff[STEPS] || q[PARAM_W-1]) begin
            t_in = signed'(~MAG_NEG);
         end else begin
            t_in = signed'(q);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cand_ff <= '{t: t_in, qual: qual_ff[STEPS]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         validp_ff <= 1'b0;
         vld_ff[0] <= 1'b0;
         validf_ff <= 1'b0;
      end else if (en) begin
         validp_ff <= in_valid;
         vld_ff[0] <= validp_ff;
         validf_ff <= vld_ff[STEPS];
      end
   end

   assign out_valid = validf_ff;
   assign out_cand  = cand_ff;

endmodule

// ----- rtl/core/ssfh_pick.sv -----
// ssfh_pick: two-stage minimum over the qualifying edge candidates.
// Depends on ssfh_pkg.
`timescale 1ns / 1ps

module ssfh_pick import ssfh_pkg::*; (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  logic                          in_valid,
   input  ssfh_cand_type [NUM_EDGES-1:0] in_cand,
   output logic                          out_valid,
   output ssfh_rsp_type                  out_rsp
);

   function automatic ssfh_cand_type pick_min(input ssfh_cand_type a,
                                              input ssfh_cand_type b);
      ssfh_cand_type r;
      if (a.qual && b.qual) begin
         r = (b.t < a.t) ? b : a;
      end else if (b.qual) begin
         r = b;
      end else begin
         r = a;
      end
      return r;
   endfunction

   // stage 1: pairs left/right and bottom/top
   ssfh_cand_type m01_ff, m23_ff;
   ssfh_cand_type best;
   ssfh_rsp_type  rsp_ff;
   logic          v1_ff, v2_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         m01_ff <= pick_min(in_cand[EDGE_LEFT], in_cand[EDGE_RIGHT]);
         m23_ff <= pick_min(in_cand[EDGE_BOTTOM], in_cand[EDGE_TOP]);
      end
   end

   // stage 2: final minimum, parameter forced to zero on a miss
   assign best = pick_min(m01_ff, m23_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_ff <= '{hit: best.qual, hit_param: (best.qual ? best.t : '0)};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
      end
   end

   assign out_valid = v2_ff;
   assign out_rsp   = rsp_ff;

endmodule

// ----- rtl/core/ssfh_skid.sv -----
// ssfh_skid: two-entry output queue; the pipeline advances while it has room.
// Depends on ssfh_pkg.
`timescale 1ns / 1ps

module ssfh_skid import ssfh_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  ssfh_rsp_type push_rsp,
   output logic         room,
   output logic         out_valid,
   input  logic         out_ready,
   output ssfh_rsp_type out_rsp
);

   ssfh_rsp_type mem_ff [0:1];
   logic         wr_ff, rd_ff;
   logic [1:0]   count_ff;
   logic         pop;

   assign pop       = out_valid && out_ready;
   assign out_valid = (count_ff != 2'd0);
   assign room      = (count_ff != 2'd2);
   assign out_rsp   = mem_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_rsp;
      end
   end

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= 1'b0;
         rd_ff    <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         if (push) begin
            wr_ff <= !wr_ff;
         end
         if (pop) begin
            rd_ff <= !rd_ff;
         end
         count_ff <= count_ff + 2'(push) - 2'(pop);
      end
   end

endmodule

// ----- sim/segment_square_first_hit_test.sv -----
// segment_square_first_hit_test: self-checking bench for the segment/square hit block.
// Depends on ssfh_pkg, ssfh_req_if, ssfh_rsp_if and segment_square_first_hit.
`timescale 1ns / 1ps

module segment_square_first_hit_test;
   import ssfh_pkg::*;

   localparam int FRAC = FRAC_BITS_DEF;
   localparam int WATCHDOG_LIMIT = 5000;

   logic clock;
   logic reset;

   ssfh_req_if req_chan ();
   ssfh_rsp_if rsp_chan ();

   segment_square_first_hit #(.FRAC_BITS(FRAC)) uut (
      .clock(clock), .reset(reset), .req_chan(req_chan), .rsp_chan(rsp_chan)
   );

   // expected hit results, oldest first
   ssfh_rsp_type hit_queue[$];
   int errors = 0;
   int requests_sent = 0;
   int results_seen = 0;
   int hits_seen = 0;
   int idle_pct = 33;        // idling rate of both sides, 0 for a burst
   bit hold_off = 0;         // receiver long stall in progress
   int quiet_cycles = 0;

   always begin
      clock = 1'b0; #5;
      clock = 1'b1; #5;
   end

   // predict a request's result: smallest qualifying t over all edges
   function automatic ssfh_rsp_type predict_hit(ssfh_req_type rq);
      ssfh_rsp_type res;
      longint sx, sy, ex, ey, cx, cy, r, dx, dy, side, px, py, rx, ry, tn, td, t, best;
      logic signed [127:0] den, num;
      bit vert, any;
      sx = rq.start_x; sy = rq.start_y; ex = rq.end_x; ey = rq.end_y;
      cx = rq.centre_x; cy = rq.centre_y; r = longint'(rq.half_size);
      dx = ex - sx; dy = ey - sy; side = 2 * r;
      any = 0; best = 0;
      for (int k = 0; k < NUM_EDGES; k++) begin
         vert = (k == EDGE_LEFT) || (k == EDGE_RIGHT);
         px = (k == EDGE_RIGHT) ? cx + r : cx - r;
         py = (k == EDGE_TOP) ? cy + r : cy - r;
         rx = px - sx; ry = py - sy;
         tn = vert ? rx : ry;
         td = vert ? dx : dy;
         if (td == 0 || side == 0) continue;
         den = 128'(side) * 128'(td);
         if (!vert) den = -den;
         num = 128'(rx) * 128'(dy) - 128'(ry) * 128'(dx);
         if (den < 0) begin
            den = -den; num = -num;
         end
         if (num < 0 || num > den) continue;
         t = (tn * (64'sd1 <<< FRAC)) / td;
         if (t > 64'sd2147483647) t = 64'sd2147483647;
         if (t < -64'sd2147483648) t = -64'sd2147483648;
         if (!any || t < best) best = t;
         any = 1;
      end
      res.hit = any;
      res.hit_param = any ? best[31:0] : '0;
      return res;
   endfunction

   // drive one request at falling edges until accepted
   task automatic send_request(ssfh_req_type rq);
      while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid     <= 1'b1;
      req_chan.start_x   <= rq.start_x;
      req_chan.start_y   <= rq.start_y;
      req_chan.end_x     <= rq.end_x;
      req_chan.end_y     <= rq.end_y;
      req_chan.centre_x  <= rq.centre_x;
      req_chan.centre_y  <= rq.centre_y;
      req_chan.half_size <= rq.half_size;
      do @(posedge clock); while (!req_chan.ready);
      hit_queue.push_back(predict_hit(rq));
      requests_sent++;
      @(negedge clock);
   endtask

   function automatic ssfh_req_type make_req(longint sx, longint sy, longint ex, longint ey,
                                             longint cx, longint cy, longint h);
      ssfh_req_type rq;
      rq.start_x = sx[31:0]; rq.start_y = sy[31:0];
      rq.end_x = ex[31:0]; rq.end_y = ey[31:0];
      rq.centre_x = cx[31:0]; rq.centre_y = cy[31:0];
      rq.half_size = h[30:0];
      return rq;
   endfunction

   function automatic logic [31:0] rand_coord();
      case ($urandom_range(3))
         0: return $urandom;
         1: return 32'($signed($urandom_range(40 << 16)) - (20 << 16));
         2: return {$urandom_range(1) ? 16'hFFFF : 16'h0000, 16'($urandom)};
         default: return 32'($signed($urandom_range(2000)) - 1000);
      endcase
   endfunction

   // receiver: random ready, plus a long hold-off when requested
   always @(negedge clock) begin
      if (reset) rsp_chan.ready <= 1'b0;
      else if (hold_off) rsp_chan.ready <= 1'b0;
      else rsp_chan.ready <= !(idle_pct > 0 && $urandom_range(99) < idle_pct);
   end

   // result checker and watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t timeout, %0d results outstanding", $time, hit_queue.size());
            $display("segment_square_first_hit_test NOT OK");
            $finish;
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            results_seen++;
            if (hit_queue.size() == 0) begin
               $display("%0t unexpected result hit=%0b t=%0d", $time,
                        rsp_chan.hit, rsp_chan.hit_param);
               errors++;
            end else begin
               ssfh_rsp_type want;
               want = hit_queue.pop_front();
               if (want.hit) hits_seen++;
               if (rsp_chan.hit !== want.hit) begin
                  $display("%0t hit mismatch: expected %0b actual %0b", $time,
                           want.hit, rsp_chan.hit);
                  errors++;
               end
               if (rsp_chan.hit_param !== want.hit_param) begin
                  $display("%0t hit_param mismatch: expected %0d actual %0d", $time,
                           want.hit_param, rsp_chan.hit_param);
                  errors++;
               end
            end
         end
      end
   end

   // directed corner cases: degenerate, parallel, corners, negative t, saturation
   task automatic test_directed();
      longint one;
      one = 64'sd1 <<< FRAC;
      send_request(make_req(0, 0, 4*one, 0, 2*one, 0, 0));              // zero half size
      send_request(make_req(-4*one, 0, 4*one, 0, 0, 0, one));           // horizontal crossing
      send_request(make_req(0, -4*one, 0, 4*one, 0, 0, one));           // vertical crossing
      send_request(make_req(-4*one, one, 4*one, one, 0, 0, one));       // along top edge
      send_request(make_req(-2*one, -2*one, 2*one, 2*one, 0, 0, one));  // through corners
      send_request(make_req(-2*one, 2*one, 2*one, -2*one, 0, 0, one));  // other diagonal
      send_request(make_req(4*one, 0, 8*one, 0, 0, 0, one));            // negative t
      send_request(make_req(-8*one, 0, -7*one, 0, 0, 0, one));          // t beyond one
      send_request(make_req(0, 0, 1, 0, 100*one, 0, one));              // saturate high
      send_request(make_req(0, 0, -1, 0, 100*one, 0, one));             // saturate low
      send_request(make_req(0, 0, one, 0, 0, 5*one, one));              // miss
      send_request(make_req(-2147483648, -2147483648, 2147483647, 2147483647,
                            0, 0, 2147483647));                          // full range
      send_request(make_req(2147483647, 2147483647, -2147483648, -2147483648,
                            2147483647, -2147483648, 2147483647));
      send_request(make_req(-2147483648, 2147483647, 2147483647, -2147483648,
                            -2147483648, 2147483647, 1));
      send_request(make_req(0, 0, 0, 0, 0, 0, one));                    // zero delta
      send_request(make_req(-3*one, 3*one, 3*one, -one, one/2, 0, one/2));
   endtask

   // random traffic, mostly segments near the square so edges qualify
   task automatic test_random(int count);
      ssfh_req_type rq;
      for (int i = 0; i < count; i++) begin
         if (i == count / 3) idle_pct = 0;
         if (i == count / 2) idle_pct = 33;
         rq.start_x = rand_coord(); rq.start_y = rand_coord();
         rq.end_x = rand_coord(); rq.end_y = rand_coord();
         rq.centre_x = rand_coord(); rq.centre_y = rand_coord();
         case ($urandom_range(3))
            0: rq.half_size = 31'($urandom);
            1: rq.half_size = 31'($urandom_range(10 << 16));
            2: rq.half_size = 31'($urandom_range(3));
            default: rq.half_size = 31'($urandom_range(2000));
         endcase
         if ($urandom_range(3) != 0) begin
            rq.centre_x = rq.start_x + 32'($signed($urandom_range(4000)) - 2000);
            rq.centre_y = rq.start_y + 32'($signed($urandom_range(4000)) - 2000);
            rq.half_size = 31'($urandom_range(3000));
         end
         send_request(rq);
      end
   endtask

   // receiver stalls for a long stretch while requests keep coming
   task automatic test_backpressure();
      fork
         begin
            hold_off = 1;
            repeat (300) @(negedge clock);
            hold_off = 0;
         end
         test_random(100);
      join
   endtask

   initial begin
      reset = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.start_x = '0; req_chan.start_y = '0;
      req_chan.end_x = '0; req_chan.end_y = '0;
      req_chan.centre_x = '0; req_chan.centre_y = '0;
      req_chan.half_size = '0;
      rsp_chan.ready = 1'b0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed();
      test_backpressure();
      test_random(1100);
      req_chan.valid <= 1'b0;

      while (hit_queue.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);

      $display("covered %0d requests, %0d results checked, %0d hits",
               requests_sent, results_seen, hits_seen);
      if (errors == 0) begin
         $display("segment_square_first_hit_test OK");
      end else begin
         $display("segment_square_first_hit_test NOT OK");
      end
      $finish;
   end

endmodule
